/* rtl/cro_pkg.sv */
// ----------------------------------------------------------------------------
// Channel reorder buffer package
// Shared constants, codes and types for the reorder buffer and its cells.
// ----------------------------------------------------------------------------
package cro_pkg;

   localparam int DEPTH        = 16;
   localparam int SEQ_BITS     = 16;
   localparam int PAYLOAD_BITS = 32;

   localparam logic [SEQ_BITS-1:0] HALF_SPAN = {1'b0, {(SEQ_BITS-1){1'b1}}};

   localparam logic [1:0] MODE_ENQUEUE  = 2'd0;
   localparam logic [1:0] MODE_DEQUEUE  = 2'd1;
   localparam logic [1:0] MODE_OUTGOING = 2'd2;

   localparam logic [2:0] STATUS_STORED    = 3'd0;
   localparam logic [2:0] STATUS_STALE     = 3'd1;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_DELIVERED = 3'd4;
   localparam logic [2:0] STATUS_NONE      = 3'd5;
   localparam logic [2:0] STATUS_OUTGOING  = 3'd6;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } cro_state_type;

   typedef struct packed {
      logic                    valid;
      logic [SEQ_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } cro_entry_type;

   typedef struct packed {
      logic                    capture;
      logic                    insert;
      logic                    pop;
      logic [SEQ_BITS-1:0]     cmp_key;
      logic [SEQ_BITS-1:0]     ins_key;
      logic [PAYLOAD_BITS-1:0] ins_payload;
   } cro_cell_ctl_type;

endpackage

/* rtl/cro_if.sv */
// ----------------------------------------------------------------------------
// Channel reorder buffer interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface cro_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       mode;
   logic [cro_pkg::SEQ_BITS-1:0]     sequence_req;
   logic [cro_pkg::PAYLOAD_BITS-1:0] payload;

   modport source (output valid, output mode, output sequence_req, output payload,
                   input ready);
   modport sink (input valid, input mode, input sequence_req, input payload,
                 output ready);
endinterface

interface cro_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       status;
   logic [cro_pkg::PAYLOAD_BITS-1:0] out_payload;
   logic [cro_pkg::SEQ_BITS-1:0]     out_sequence;

   modport source (output valid, output status, output out_payload, output out_sequence,
                   input ready);
   modport sink (input valid, input status, input out_payload, input out_sequence,
                 output ready);
endinterface

/* rtl/channel_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// Channel reorder buffer
// Per-channel packet reorder buffer built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Request beats on req_chan carry a mode (enqueue, dequeue head, take next
// outgoing number), a sequence number and a payload handle. Each request
// produces exactly one response beat on rsp_chan with a status, a payload
// handle and a sequence number. The csr port sets the channel mode: ordered
// delivery or sequenced delivery that drops stale packets.
// Entries sit in a row of cells kept sorted by key, smallest at the head.
// In the accept cycle of a request every cell latches its compare flags
// against the incoming key. Then in ST_EXEC, once no response is pending
// or the pending one is taken, the chain shifts in one step to insert or
// pop and the response register is loaded. A new request is accepted only
// in ST_IDLE, after the last one has committed. If the receiver stalls, one
// response waits in the output register while the next request is accepted;
// its commit then waits until that response is taken.
// Reset clears the valid bit of every cell and the sequence counters directly;
// no clearing pass follows.
// ----------------------------------------------------------------------------
module channel_reorder_buffer (
   input  logic    clock,
   input  logic    reset,
   cro_req_if.sink req_chan,
   cro_rsp_if.source rsp_chan,
   input  logic    csr_we,
   input  logic    csr_wdata
);
   import cro_pkg::*;

   cro_state_type           state_ff, state_in;
   logic                    channel_mode_ff;
   logic [1:0]              cmd_mode_ff;
   logic [SEQ_BITS-1:0]     cmd_seq_ff;
   logic [PAYLOAD_BITS-1:0] cmd_payload_ff;
   logic [SEQ_BITS-1:0]     next_enqueue_ff, next_enqueue_in;
   logic [SEQ_BITS-1:0]     next_dequeue_ff, next_dequeue_in;
   logic [SEQ_BITS-1:0]     outgoing_ff, outgoing_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_BITS-1:0] rsp_payload_ff, rsp_payload_in;
   logic [SEQ_BITS-1:0]     rsp_sequence_ff, rsp_sequence_in;

   cro_cell_ctl_type        ctl;
   logic                    accept;
   logic                    commit;
   cro_entry_type           cell_entry [DEPTH];
   logic [DEPTH-1:0]        gt_vec;
   logic [DEPTH-1:0]        eq_vec;
   logic [DEPTH-1:0]        vld_vec;
   logic [DEPTH-1:0]        sorted_ok;
   logic [SEQ_BITS-1:0]     enq_dist;
   logic [SEQ_BITS-1:0]     deq_dist;
   logic                    stale;
   logic                    eligible;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cro_entry_type prev_e;
      cro_entry_type next_e;
      logic          prev_g;
      if (i == 0) begin : g_first
         assign prev_e = '0;
         assign prev_g = 1'b0;
      end else begin : g_mid
         assign prev_e = cell_entry[i-1];
         assign prev_g = gt_vec[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign next_e = '0;
      end else begin : g_rest
         assign next_e = cell_entry[i+1];
      end
      cro_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_entry (prev_e),
         .prev_gt    (prev_g),
         .next_entry (next_e),
         .entry      (cell_entry[i]),
         .gt         (gt_vec[i]),
         .eq         (eq_vec[i])
      );
      assign vld_vec[i] = cell_entry[i].valid;
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (i == DEPTH-1) begin
            sorted_ok[i] = 1'b1;
         end else begin
            sorted_ok[i] = !cell_entry[i+1].valid ||
                           (cell_entry[i].valid && (cell_entry[i].key < cell_entry[i+1].key));
         end
      end
   end

   assign accept   = req_chan.valid && req_chan.ready;
   assign enq_dist = next_enqueue_ff - cmd_seq_ff;
   assign deq_dist = cell_entry[0].key - next_dequeue_ff;
   assign stale    = (cmd_seq_ff != next_enqueue_ff) && (enq_dist < HALF_SPAN);
   assign eligible = cell_entry[0].valid &&
                     (channel_mode_ff || (cell_entry[0].key == next_dequeue_ff) ||
                      (deq_dist > HALF_SPAN));

   always_comb begin
      state_in        = state_ff;
      next_enqueue_in = next_enqueue_ff;
      next_dequeue_in = next_dequeue_ff;
      outgoing_in     = outgoing_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_sequence_in = rsp_sequence_ff;
      commit          = 1'b0;
      ctl.capture     = accept;
      ctl.insert      = 1'b0;
      ctl.pop         = 1'b0;
      ctl.cmp_key     = req_chan.sequence_req;
      ctl.ins_key     = cmd_seq_ff;
      ctl.ins_payload = cmd_payload_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               commit          = 1'b1;
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = STATUS_NONE;
               rsp_payload_in  = '0;
               rsp_sequence_in = '0;
               unique case (cmd_mode_ff)
                  MODE_ENQUEUE: begin
                     if (channel_mode_ff && stale) begin
                        rsp_status_in = STATUS_STALE;
                     end else begin
                        if (channel_mode_ff) begin
                           next_enqueue_in = SEQ_BITS'(cmd_seq_ff + 1'b1);
                        end
                        priority if (|eq_vec) begin
                           rsp_status_in = STATUS_DUPLICATE;
                        end else if (vld_vec[DEPTH-1]) begin
                           rsp_status_in = STATUS_FULL;
                        end else begin
                           rsp_status_in = STATUS_STORED;
                           ctl.insert    = 1'b1;
                        end
                     end
                  end
                  MODE_DEQUEUE: begin
                     if (eligible) begin
                        rsp_status_in   = STATUS_DELIVERED;
                        rsp_payload_in  = cell_entry[0].payload;
                        rsp_sequence_in = cell_entry[0].key;
                        next_dequeue_in = SEQ_BITS'(cell_entry[0].key + 1'b1);
                        ctl.pop         = 1'b1;
                     end
                  end
                  MODE_OUTGOING: begin
                     rsp_status_in   = STATUS_OUTGOING;
                     rsp_sequence_in = outgoing_ff;
                     outgoing_in     = SEQ_BITS'(outgoing_ff + 1'b1);
                  end
                  default: begin
                     rsp_status_in = STATUS_NONE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         channel_mode_ff <= 1'b0;
         next_enqueue_ff <= '0;
         next_dequeue_ff <= '0;
         outgoing_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         next_enqueue_ff <= next_enqueue_in;
         next_dequeue_ff <= next_dequeue_in;
         outgoing_ff     <= outgoing_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_we) begin
            channel_mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_sequence_ff <= rsp_sequence_in;
      if (accept) begin
         cmd_mode_ff    <= req_chan.mode;
         cmd_seq_ff     <= req_chan.sequence_req;
         cmd_payload_ff <= req_chan.payload;
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_payload  = rsp_payload_ff;
   assign rsp_chan.out_sequence = rsp_sequence_ff;

   // Valid entries stay packed at the head of the chain.
   a_packed: assert property (@(posedge clock) disable iff (reset)
      (vld_vec & (vld_vec + 1'b1)) == '0)
      else $error("reorder chain has a gap between valid cells");

   // Valid entries stay in strictly ascending key order.
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      &sorted_ok)
      else $error("reorder chain is out of key order");

   // A commit never overwrites a response beat that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      commit |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response beat overwritten before it was taken");

   // An insert never happens with a full chain, so no entry falls off the end.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |-> !vld_vec[DEPTH-1])
      else $error("insert into a full reorder chain");

endmodule

/* rtl/cro_cell.sv */
// ----------------------------------------------------------------------------
// Reorder buffer cell
// One slot of the sorted chain: holds an entry, latches its compare flags
// against an incoming key, and on a shift takes the new entry or data from either neighbor.
// ----------------------------------------------------------------------------
module cro_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  cro_pkg::cro_cell_ctl_type ctl,
   input  cro_pkg::cro_entry_type    prev_entry,
   input  logic                      prev_gt,
   input  cro_pkg::cro_entry_type    next_entry,
   output cro_pkg::cro_entry_type    entry,
   output logic                      gt,
   output logic                      eq
);
   import cro_pkg::*;

   cro_entry_type entry_ff, entry_in;
   logic          gt_ff, gt_in;
   logic          eq_ff, eq_in;

   always_comb begin
      gt_in    = gt_ff;
      eq_in    = eq_ff;
      entry_in = entry_ff;
      if (ctl.capture) begin
         gt_in = !entry_ff.valid || (entry_ff.key > ctl.cmp_key);
         eq_in = entry_ff.valid && (entry_ff.key == ctl.cmp_key);
      end
      priority if (ctl.insert && gt_ff && !prev_gt) begin
         entry_in.valid   = 1'b1;
         entry_in.key     = ctl.ins_key;
         entry_in.payload = ctl.ins_payload;
      end else if (ctl.insert && gt_ff) begin
         entry_in = prev_entry;
      end else if (ctl.pop) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.key     <= entry_in.key;
      entry_ff.payload <= entry_in.payload;
      gt_ff            <= gt_in;
      eq_ff            <= eq_in;
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

/* sim/channel_reorder_buffer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Channel reorder buffer testbench
// Drives request beats through the reorder buffer in ordered and sequenced
// mode and checks every response beat against a cycle-free model of the
// sorted entry store, the stale-drop window and the outgoing counter. A short
// directed pass covers the corner cases, and random traffic follows with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module channel_reorder_buffer_test;
   import cro_pkg::*;

   localparam logic [1:0] MODE_UNUSED       = 2'd3;
   localparam logic       CHANNEL_ORDERED   = 1'b0;
   localparam logic       CHANNEL_SEQUENCED = 1'b1;
   localparam int         IDLE_LIMIT        = 2000;
   localparam int         RANDOM_PHASES     = 6;
   localparam int         PHASE_BEATS       = 190;
   localparam int         SETTLE_CYCLES     = 4;

   typedef struct packed {
      logic [2:0]              status;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [SEQ_BITS-1:0]     seq_num;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic csr_wdata;

   cro_req_if req_bus();
   cro_rsp_if rsp_bus();

   channel_reorder_buffer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   bit [SEQ_BITS-1:0]     stored_keys [DEPTH];
   bit [PAYLOAD_BITS-1:0] stored_payloads [DEPTH];
   bit                    stored_valid [DEPTH];
   bit [SEQ_BITS-1:0]     next_enqueue_seq;
   bit [SEQ_BITS-1:0]     next_dequeue_seq;
   bit [SEQ_BITS-1:0]     outgoing_seq;
   bit                    channel_mode;

   rsp_beat_type expected_responses [$];
   int           mismatch_count = 0;
   int           idle_cycles = 0;
   bit           no_idle = 1'b0;

   always #4 clock = ~clock;

   function automatic rsp_beat_type predict_response(logic [1:0] op,
                                                     logic [SEQ_BITS-1:0] seq,
                                                     logic [PAYLOAD_BITS-1:0] pay);
      rsp_beat_type        beat;
      int                  free_slot;
      int                  head;
      bit [SEQ_BITS-1:0]   seq_gap;
      beat = '{status: STATUS_NONE, payload: '0, seq_num: '0};
      free_slot = -1;
      head = -1;
      case (op)
         MODE_ENQUEUE: begin
            seq_gap = next_enqueue_seq - seq;
            if (channel_mode == CHANNEL_SEQUENCED) begin
               if (seq != next_enqueue_seq && seq_gap < HALF_SPAN) begin
                  beat.status = STATUS_STALE;
                  return beat;
               end
               next_enqueue_seq = seq + 1'b1;
            end
            for (int i = 0; i < DEPTH; i++) begin
               if (stored_valid[i] && stored_keys[i] == seq) begin
                  beat.status = STATUS_DUPLICATE;
                  return beat;
               end
               if (!stored_valid[i] && free_slot < 0)
                  free_slot = i;
            end
            if (free_slot < 0) begin
               beat.status = STATUS_FULL;
               return beat;
            end
            stored_keys[free_slot] = seq;
            stored_payloads[free_slot] = pay;
            stored_valid[free_slot] = 1'b1;
            beat.status = STATUS_STORED;
         end
         MODE_DEQUEUE: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (stored_valid[i] && (head < 0 || stored_keys[i] < stored_keys[head]))
                  head = i;
            end
            if (head >= 0) begin
               seq_gap = stored_keys[head] - next_dequeue_seq;
               if (channel_mode == CHANNEL_SEQUENCED || stored_keys[head] == next_dequeue_seq ||
                   seq_gap > HALF_SPAN) begin
                  next_dequeue_seq = stored_keys[head] + 1'b1;
                  stored_valid[head] = 1'b0;
                  beat.status = STATUS_DELIVERED;
                  beat.payload = stored_payloads[head];
                  beat.seq_num = stored_keys[head];
               end
            end
         end
         MODE_OUTGOING: begin
            beat.status = STATUS_OUTGOING;
            beat.seq_num = outgoing_seq;
            outgoing_seq = outgoing_seq + 1'b1;
         end
         default: ;
      endcase
      return beat;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic send_beat(logic [1:0] op, logic [SEQ_BITS-1:0] seq,
                            logic [PAYLOAD_BITS-1:0] pay);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.mode <= op;
      req_bus.sequence_req <= seq;
      req_bus.payload <= pay;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_responses.push_back(predict_response(op, seq, pay));
   endtask

   // Must be called right after a beat is accepted, so that valid drops
   // before the next rising edge.
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_channel_mode(logic value);
      wait_for_drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      channel_mode = value;
   endtask

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_response();
      rsp_beat_type want;
      if (expected_responses.size() == 0) begin
         $display("%0t: response beat expected none, got status %h payload %h sequence %h",
                  $time, rsp_bus.status, rsp_bus.out_payload, rsp_bus.out_sequence);
         mismatch_count++;
      end else begin
         want = expected_responses.pop_front();
         compare_field("status", 32'(want.status), 32'(rsp_bus.status));
         compare_field("out_payload", want.payload, rsp_bus.out_payload);
         compare_field("out_sequence", 32'(want.seq_num), 32'(rsp_bus.out_sequence));
      end
   endtask

   task automatic test_ordered_basics();
      write_channel_mode(CHANNEL_ORDERED);
      send_beat(MODE_DEQUEUE, '0, '0);
      send_beat(MODE_UNUSED, '1, '1);
      send_beat(MODE_OUTGOING, '0, '0);
      send_beat(MODE_ENQUEUE, 16'd1, '1);
      send_beat(MODE_DEQUEUE, '0, '0);
      send_beat(MODE_ENQUEUE, 16'd0, '0);
      send_beat(MODE_DEQUEUE, '0, '0);
      send_beat(MODE_ENQUEUE, 16'd1, 32'h1234_5678);
      send_beat(MODE_DEQUEUE, '0, '0);
   endtask

   task automatic test_sequenced_drops();
      write_channel_mode(CHANNEL_SEQUENCED);
      send_beat(MODE_ENQUEUE, 16'hffff, 32'h0000_0001);
      send_beat(MODE_ENQUEUE, 16'd10, 32'h0000_000a);
      send_beat(MODE_ENQUEUE, 16'd7, 32'h0000_0007);
      send_beat(MODE_ENQUEUE, 16'd40000, 32'h0000_9c40);
      send_beat(MODE_ENQUEUE, 16'd30000, 32'h0000_7530);
      send_beat(MODE_DEQUEUE, '0, '0);
      send_beat(MODE_ENQUEUE, 16'd10, 32'hdead_beef);
   endtask

   task automatic test_full_table();
      for (int k = 1; k <= DEPTH; k++)
         send_beat(MODE_ENQUEUE, SEQ_BITS'(30000 + k), $urandom);
   endtask

   // Most beats stay in a small window around the next expected number, so
   // the store fills, drains and delivers in order; a few beats are noise.
   task automatic test_random_traffic();
      int                enqueue_share;
      int                pick;
      logic [SEQ_BITS-1:0] window_base;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_channel_mode(phase % 2 == 0 ? CHANNEL_SEQUENCED : CHANNEL_ORDERED);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n % 40 == 0) begin
               enqueue_share = $urandom_range(25, 65);
               no_idle = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            window_base = (channel_mode == CHANNEL_SEQUENCED) ? next_enqueue_seq
                                                              : next_dequeue_seq;
            if (pick < 4)
               send_beat(MODE_UNUSED, SEQ_BITS'($urandom), $urandom);
            else if (pick < 9)
               send_beat(MODE_ENQUEUE, SEQ_BITS'($urandom), $urandom);
            else if (pick < 16)
               send_beat(MODE_OUTGOING, SEQ_BITS'($urandom), $urandom);
            else if (pick < 16 + enqueue_share)
               send_beat(MODE_ENQUEUE, SEQ_BITS'(window_base + $urandom_range(0, 7) - 2),
                         $urandom);
            else
               send_beat(MODE_DEQUEUE, SEQ_BITS'($urandom), $urandom);
         end
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) === 1'b1 ||
          (rsp_bus.valid && rsp_bus.ready) === 1'b1)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_gap();
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         check_response();
      end
   end

   initial begin
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_ENQUEUE;
      req_bus.sequence_req = '0;
      req_bus.payload = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_ordered_basics();
      test_sequenced_drops();
      test_full_table();
      test_random_traffic();
      wait_for_drain();
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
